// File: rtl/core/f2h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2h_pkg
// Shared types and constants for the float32 pair to half2x16 unit.
// ----------------------------------------------------------------------------
package f2h_pkg;

  localparam int unsigned FloatW = 32;
  localparam int unsigned HalfW  = 16;

  localparam logic [15:0] HalfNan    = 16'h7FFF;
  localparam logic [15:0] HalfInf    = 16'h7C00;
  localparam logic [10:0] HalfManMax = 11'h3FF;
  localparam logic [22:0] RoundHalf  = 23'h001000;

  // result class decided in the first stage
  typedef enum logic [2:0] {
    CLS_NAN,
    CLS_INF,
    CLS_ZERO,
    CLS_SUB,
    CLS_NORM
  } f2h_cls_t;

  // per-lane state after classification
  typedef struct packed {
    logic        sign;
    f2h_cls_t    cls;
    logic [4:0]  hexp;
    logic [23:0] man;
  } f2h_cls_lane_t;

  // per-lane state after rounding add
  typedef struct packed {
    logic        sign;
    f2h_cls_t    cls;
    logic [4:0]  hexp;
    logic [11:0] rnd;
  } f2h_rnd_lane_t;

endpackage

// File: rtl/core/f2h_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2h_stream_if
// Valid/ready channel carrying a fixed-width payload.
// ----------------------------------------------------------------------------
interface f2h_stream_if #(
  parameter int unsigned DataW = 64
);
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/f2h_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2h_classify
// Stage one: classifies a single-precision value and aligns its mantissa.
// ----------------------------------------------------------------------------
module f2h_classify (
  input  logic [31:0]            float_bits,
  output f2h_pkg::f2h_cls_lane_t lane
);
  import f2h_pkg::*;

  logic [7:0]  bexp;
  logic [22:0] mant;
  logic [4:0]  shamt;

  assign bexp  = float_bits[30:23];
  assign mant  = float_bits[22:0];
  // right shift for half subnormals: 113 - bexp, range 1..11
  assign shamt = 5'(8'd113 - bexp);

  // class and aligned mantissa
  always_comb begin
    lane.sign = float_bits[31];
    lane.hexp = 5'(bexp - 8'd112);
    lane.man  = {1'b0, mant};
    if (bexp == 8'hFF) begin
      lane.cls = (mant != '0) ? CLS_NAN : CLS_INF;
    end else if (bexp < 8'd102) begin
      lane.cls = CLS_ZERO;
    end else if (bexp <= 8'd112) begin
      lane.cls = CLS_SUB;
      lane.man = {1'b1, mant} >> shamt;
    end else if (bexp >= 8'd143) begin
      lane.cls = CLS_INF;
    end else begin
      lane.cls = CLS_NORM;
    end
  end
endmodule

// File: rtl/core/f2h_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2h_round
// Stage two: adds half an ulp and truncates to the half mantissa width.
// ----------------------------------------------------------------------------
module f2h_round (
  input  f2h_pkg::f2h_cls_lane_t cls_lane,
  output f2h_pkg::f2h_rnd_lane_t rnd_lane
);
  import f2h_pkg::*;

  logic [24:0] sum;

  assign sum = {1'b0, cls_lane.man} + {2'b00, RoundHalf};

  always_comb begin
    rnd_lane.sign = cls_lane.sign;
    rnd_lane.cls  = cls_lane.cls;
    rnd_lane.hexp = cls_lane.hexp;
    rnd_lane.rnd  = sum[24:13];
  end
endmodule

// File: rtl/core/f2h_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2h_pack
// Stage three: handles carry, saturation and special codes per half.
// ----------------------------------------------------------------------------
module f2h_pack (
  input  f2h_pkg::f2h_rnd_lane_t rnd_lane,
  output logic [15:0]            half_bits
);
  import f2h_pkg::*;

  logic [5:0] exp_inc;

  assign exp_inc = {1'b0, rnd_lane.hexp} + 6'd1;

  // final encoding
  always_comb begin
    case (rnd_lane.cls)
      CLS_NAN:  half_bits = HalfNan;
      CLS_INF:  half_bits = {rnd_lane.sign, HalfInf[14:0]};
      CLS_ZERO: half_bits = {rnd_lane.sign, 15'd0};
      CLS_SUB: begin
        if (rnd_lane.rnd > {1'b0, HalfManMax}) begin
          half_bits = {rnd_lane.sign, 5'd0, HalfManMax[9:0]};
        end else begin
          half_bits = {rnd_lane.sign, 5'd0, rnd_lane.rnd[9:0]};
        end
      end
      CLS_NORM: begin
        if (rnd_lane.rnd > {1'b0, HalfManMax}) begin
          if (exp_inc >= 6'd31) begin
            half_bits = {rnd_lane.sign, HalfInf[14:0]};
          end else begin
            half_bits = {rnd_lane.sign, exp_inc[4:0], 10'd0};
          end
        end else begin
          half_bits = {rnd_lane.sign, rnd_lane.hexp, rnd_lane.rnd[9:0]};
        end
      end
      default:  half_bits = HalfNan;
    endcase
  end
endmodule

// File: rtl/core/float32_pair_to_half2x16_unit.sv
`timescale 1ns / 1ps
// Pipeline: the input transaction passes three register stages (s1, s2, s3) before the result is valid.
// Throughput: one transaction per cycle; a stall holds every valid stage in place,
// a bubble stage is filled while a later stage waits.
// Reset: synchronous active-low rst_n clears the stage valid bits only.
// ----------------------------------------------------------------------------
// float32_pair_to_half2x16_unit
// Converts two single-precision patterns to halves packed into one word.
// ----------------------------------------------------------------------------
module float32_pair_to_half2x16_unit (
  input  logic             clk,
  input  logic             rst_n,
  f2h_stream_if.sink       in_chan,
  f2h_stream_if.source     out_chan
);
  import f2h_pkg::*;

  logic          s1_valid_r, s2_valid_r, s3_valid_r;
  logic          s1_en, s2_en, s3_en;
  f2h_cls_lane_t cls_lo, cls_hi;
  f2h_cls_lane_t s1_lo_r, s1_hi_r;
  f2h_rnd_lane_t rnd_lo, rnd_hi;
  f2h_rnd_lane_t s2_lo_r, s2_hi_r;
  logic [15:0]   half_lo, half_hi;
  logic [31:0]   s3_data_r;

  // stall control: a stage loads when empty or when the next one moves
  assign s3_en = !s3_valid_r || out_chan.ready;
  assign s2_en = !s2_valid_r || s3_en;
  assign s1_en = !s1_valid_r || s2_en;
  assign in_chan.ready = s1_en;

  f2h_classify u_cls_lo (.float_bits(in_chan.data[31:0]),  .lane(cls_lo));
  f2h_classify u_cls_hi (.float_bits(in_chan.data[63:32]), .lane(cls_hi));
  f2h_round    u_rnd_lo (.cls_lane(s1_lo_r), .rnd_lane(rnd_lo));
  f2h_round    u_rnd_hi (.cls_lane(s1_hi_r), .rnd_lane(rnd_hi));
  f2h_pack     u_pck_lo (.rnd_lane(s2_lo_r), .half_bits(half_lo));
  f2h_pack     u_pck_hi (.rnd_lane(s2_hi_r), .half_bits(half_hi));

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= in_chan.valid;
      if (s2_en) s2_valid_r <= s1_valid_r;
      if (s3_en) s3_valid_r <= s2_valid_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_lo_r <= cls_lo;
      s1_hi_r <= cls_hi;
    end
    if (s2_en) begin
      s2_lo_r <= rnd_lo;
      s2_hi_r <= rnd_hi;
    end
    if (s3_en) begin
      s3_data_r <= {half_hi, half_lo};
    end
  end

  assign out_chan.valid = s3_valid_r;
  assign out_chan.data  = s3_data_r;
endmodule
